// ===== hw/rtl/bpf_pkg.sv =====
// shared types, constants and the arctangent table for the branch power flow block
package bpf_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int FLOW_STAGES  = 6;
    localparam int SQRT_STEPS   = 32;
    // input register, cordic cells, flow stages, sqrt cells
    localparam int PIPE_STAGES  = 1 + CORDIC_STEPS + FLOW_STAGES + SQRT_STEPS;

    localparam logic signed [28:0] ANG_PI      = 29'sd52707179;
    localparam logic signed [28:0] ANG_HALF_PI = 29'sd26353589;
    localparam logic signed [28:0] ANG_TWO_PI  = 29'sd105414357;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    typedef struct packed {
        logic signed [23:0] gff;
        logic signed [23:0] bff;
        logic signed [23:0] gft;
        logic signed [23:0] bft;
        logic signed [23:0] gtf;
        logic signed [23:0] btf;
        logic signed [23:0] gtt;
        logic signed [23:0] btt;
        logic        [31:0] vv;
        logic        [31:0] vf2;
        logic        [31:0] vt2;
    } t_line;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [27:0] z;
        logic               flip;
    } t_cord;

    typedef struct packed {
        logic signed [31:0] pf;
        logic signed [31:0] qf;
        logic signed [31:0] pt;
        logic signed [31:0] qt;
    } t_pq;

    typedef struct packed {
        t_pq         pq;
        logic [63:0] rem_f;
        logic [63:0] rem_t;
        logic [31:0] rt_f;
        logic [31:0] rt_t;
    } t_sq;

    function automatic logic signed [27:0] bpf_atan(input int unsigned step);
        case (step)
            0:       return 28'sd13176795;
            1:       return 28'sd7778716;
            2:       return 28'sd4110060;
            3:       return 28'sd2086331;
            4:       return 28'sd1047214;
            5:       return 28'sd524117;
            6:       return 28'sd262123;
            7:       return 28'sd131069;
            8:       return 28'sd65536;
            9:       return 28'sd32768;
            10:      return 28'sd16384;
            11:      return 28'sd8192;
            12:      return 28'sd4096;
            13:      return 28'sd2048;
            14:      return 28'sd1024;
            15:      return 28'sd512;
            16:      return 28'sd256;
            17:      return 28'sd128;
            18:      return 28'sd64;
            19:      return 28'sd32;
            20:      return 28'sd16;
            21:      return 28'sd8;
            22:      return 28'sd4;
            23:      return 28'sd2;
            default: return 28'sd0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/branch_power_flow_eval.sv =====
// path: input register, cordic cells, flow stages and sqrt cells, then the output register drives o_valid
// throughput: one request per cycle while the skid is empty; all 63 stages step together on one enable
// a skid register holds one result when the output stalls, so one more request is taken
// reset: synchronous active low, clears stage valids, output and skid valids, o_ready low
// datapath registers are not reset
module branch_power_flow_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [23:0]  i_g_from_from,
    input  logic signed [23:0]  i_b_from_from,
    input  logic signed [23:0]  i_g_from_to,
    input  logic signed [23:0]  i_b_from_to,
    input  logic signed [23:0]  i_g_to_from,
    input  logic signed [23:0]  i_b_to_from,
    input  logic signed [23:0]  i_g_to_to,
    input  logic signed [23:0]  i_b_to_to,
    input  logic        [15:0]  i_vmag_from,
    input  logic        [15:0]  i_vmag_to,
    input  logic signed [15:0]  i_angle_from,
    input  logic signed [15:0]  i_angle_to,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_p_from,
    output logic signed [31:0]  o_q_from,
    output logic signed [31:0]  o_p_to,
    output logic signed [31:0]  o_q_to,
    output logic        [30:0]  o_s_from,
    output logic        [30:0]  o_s_to
);
    import bpf_pkg::*;

    localparam int FLOW_IDX = 1 + CORDIC_STEPS;
    localparam int SQRT_IDX = FLOW_IDX + FLOW_STAGES;

    // one valid per stage, all stages advance on w_en
    logic [PIPE_STAGES-1:0] r_vld;
    logic                   w_en;

    // stage 0: angle reduction and voltage products
    t_cord r_cord0, n_cord0;
    t_line r_line0, n_line0;
    logic signed [16:0] w_dang;
    logic signed [28:0] w_z0, w_z1, w_z2;

    // chains
    t_cord w_cord [0:CORDIC_STEPS];
    t_line w_line [0:CORDIC_STEPS];
    t_sq   w_sq   [0:SQRT_STEPS];

    // output register and skid
    t_pq         w_res_pq;
    logic [30:0] w_res_sf, w_res_st;
    logic [32:0] w_rnd_f, w_rnd_t;
    t_pq         r_out_pq, r_skid_pq;
    logic [30:0] r_out_sf, r_out_st, r_skid_sf, r_skid_st;
    logic        r_ov, r_sv;
    logic        w_take;

    // pipeline moves whenever the skid is free
    assign w_en    = !r_sv;
    // no request is taken while reset is held
    assign o_ready = w_en && i_rst_n;
    assign w_take  = r_ov && i_ready;

    always_comb begin
        // angle difference in q.24, once into [-pi, pi], then into [-pi/2, pi/2]
        w_dang = $signed({i_angle_from[15], i_angle_from}) -
                 $signed({i_angle_to[15], i_angle_to});
        w_z0   = $signed({w_dang[16], w_dang, 11'd0});
        w_z1   = w_z0;
        if (w_z0 > ANG_PI) begin
            w_z1 = w_z0 - ANG_TWO_PI;
        end
        if (w_z1 < -ANG_PI) begin
            w_z1 = w_z1 + ANG_TWO_PI;
        end
        n_cord0.flip = 1'b0;
        w_z2         = w_z1;
        if (w_z1 > ANG_HALF_PI) begin
            w_z2         = w_z1 - ANG_PI;
            n_cord0.flip = 1'b1;
        end else if (w_z1 < -ANG_HALF_PI) begin
            w_z2         = w_z1 + ANG_PI;
            n_cord0.flip = 1'b1;
        end
        n_cord0.x = CORDIC_GAIN;
        n_cord0.y = '0;
        n_cord0.z = w_z2[27:0];

        n_line0.gff = i_g_from_from;
        n_line0.bff = i_b_from_from;
        n_line0.gft = i_g_from_to;
        n_line0.bft = i_b_from_to;
        n_line0.gtf = i_g_to_from;
        n_line0.btf = i_b_to_from;
        n_line0.gtt = i_g_to_to;
        n_line0.btt = i_b_to_to;
        n_line0.vv  = i_vmag_from * i_vmag_to;
        n_line0.vf2 = i_vmag_from * i_vmag_from;
        n_line0.vt2 = i_vmag_to * i_vmag_to;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cord0 <= n_cord0;
            r_line0 <= n_line0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], i_valid};
        end
    end

    assign w_cord[0] = r_cord0;
    assign w_line[0] = r_line0;

    // cordic chain, one rotation per cell
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        bpf_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cord (w_cord[g]),
            .i_line (w_line[g]),
            .o_cord (w_cord[g+1]),
            .o_line (w_line[g+1])
        );
    end

    // brackets, flows, squared magnitudes
    bpf_flow u_flow (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cord (w_cord[CORDIC_STEPS]),
        .i_line (w_line[CORDIC_STEPS]),
        .o_sq   (w_sq[0])
    );

    // root chain, one digit per cell, msb first
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        bpf_sqrt_cell #(
            .K (SQRT_STEPS - 1 - g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_sq  (w_sq[g]),
            .o_sq  (w_sq[g+1])
        );
    end

    // round the floor root up when the remainder passes the root, then saturate
    always_comb begin
        w_res_pq = w_sq[SQRT_STEPS].pq;
        w_rnd_f  = {1'b0, w_sq[SQRT_STEPS].rt_f};
        w_rnd_t  = {1'b0, w_sq[SQRT_STEPS].rt_t};
        if (w_sq[SQRT_STEPS].rem_f > {32'd0, w_sq[SQRT_STEPS].rt_f}) begin
            w_rnd_f = w_rnd_f + 33'd1;
        end
        if (w_sq[SQRT_STEPS].rem_t > {32'd0, w_sq[SQRT_STEPS].rt_t}) begin
            w_rnd_t = w_rnd_t + 33'd1;
        end
        w_res_sf = (w_rnd_f > 33'h07FFFFFFF) ? 31'h7FFFFFFF : w_rnd_f[30:0];
        w_res_st = (w_rnd_t > 33'h07FFFFFFF) ? 31'h7FFFFFFF : w_rnd_t[30:0];
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_take) begin
                r_out_pq <= r_skid_pq;
                r_out_sf <= r_skid_sf;
                r_out_st <= r_skid_st;
                r_sv     <= 1'b0;
            end
        end else if (r_vld[PIPE_STAGES-1]) begin
            if (!r_ov || w_take) begin
                r_out_pq <= w_res_pq;
                r_out_sf <= w_res_sf;
                r_out_st <= w_res_st;
                r_ov     <= 1'b1;
            end else begin
                r_skid_pq <= w_res_pq;
                r_skid_sf <= w_res_sf;
                r_skid_st <= w_res_st;
                r_sv      <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid  = r_ov;
    assign o_p_from = r_out_pq.pf;
    assign o_q_from = r_out_pq.qf;
    assign o_p_to   = r_out_pq.pt;
    assign o_q_to   = r_out_pq.qt;
    assign o_s_from = r_out_sf;
    assign o_s_to   = r_out_st;
endmodule

// ===== hw/rtl/bpf_cordic_cell.sv =====
// one cordic rotation cell, carries the line data alongside
module bpf_cordic_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  bpf_pkg::t_cord  i_cord,
    input  bpf_pkg::t_line  i_line,
    output bpf_pkg::t_cord  o_cord,
    output bpf_pkg::t_line  o_line
);
    import bpf_pkg::*;

    localparam logic signed [27:0] ATAN = bpf_atan(STEP);

    t_cord r_cord, n_cord;
    t_line r_line;
    logic signed [31:0] w_xs, w_ys;

    always_comb begin
        w_xs   = $signed(i_cord.x) >>> STEP;
        w_ys   = $signed(i_cord.y) >>> STEP;
        n_cord = i_cord;
        if (!i_cord.z[27]) begin
            n_cord.x = $signed(i_cord.x) - w_ys;
            n_cord.y = $signed(i_cord.y) + w_xs;
            n_cord.z = $signed(i_cord.z) - ATAN;
        end else begin
            n_cord.x = $signed(i_cord.x) + w_ys;
            n_cord.y = $signed(i_cord.y) - w_xs;
            n_cord.z = $signed(i_cord.z) + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cord <= n_cord;
            r_line <= i_line;
        end
    end

    assign o_cord = r_cord;
    assign o_line = r_line;
endmodule

// ===== hw/rtl/bpf_flow.sv =====
// multiply pipeline: brackets, flows with rounding and saturation, squared magnitudes
module bpf_flow (
    input  logic            i_clk,
    input  logic            i_en,
    input  bpf_pkg::t_cord  i_cord,
    input  bpf_pkg::t_line  i_line,
    output bpf_pkg::t_sq    o_sq
);
    import bpf_pkg::*;

    localparam logic signed [57:0] BR_RND = 58'sd1 << 29;
    localparam logic signed [61:0] PQ_RND = 62'sd1 << 23;
    localparam logic signed [37:0] SAT_HI = 38'sd2147483647;
    localparam logic signed [37:0] SAT_LO = -38'sd2147483648;

    // stage 1
    t_line r1_line;
    logic signed [55:0] r1_p [0:7];
    // stage 2
    logic signed [27:0] r2_br [0:3];
    logic signed [56:0] r2_self [0:3];
    logic        [31:0] r2_vv;
    // stage 3
    logic signed [60:0] r3_m [0:3];
    logic signed [56:0] r3_self [0:3];
    // stage 4
    t_pq r4_pq;
    // stage 5
    t_pq r5_pq;
    logic [62:0] r5_sq [0:3];
    // stage 6
    t_sq r6_sq;

    logic signed [31:0] w_c, w_s;
    logic signed [57:0] w_br [0:3];
    logic signed [61:0] w_sum [0:3];
    logic signed [37:0] w_rnd [0:3];
    logic signed [31:0] w_sat [0:3];
    logic signed [63:0] w_sq [0:3];

    always_comb begin
        w_c = i_cord.flip ? -$signed(i_cord.x) : $signed(i_cord.x);
        w_s = i_cord.flip ? -$signed(i_cord.y) : $signed(i_cord.y);
        // from end uses sin(d), to end -sin(d): signs are folded in here
        w_br[0] = 58'(r1_p[0]) + 58'(r1_p[1]) + BR_RND;
        w_br[1] = -58'(r1_p[2]) + 58'(r1_p[3]) + BR_RND;
        w_br[2] = 58'(r1_p[4]) - 58'(r1_p[5]) + BR_RND;
        w_br[3] = -58'(r1_p[6]) - 58'(r1_p[7]) + BR_RND;
        w_sum[0] = 62'(r3_self[0]) + 62'(r3_m[0]) + PQ_RND;
        w_sum[1] = -62'(r3_self[1]) + 62'(r3_m[1]) + PQ_RND;
        w_sum[2] = 62'(r3_self[2]) + 62'(r3_m[2]) + PQ_RND;
        w_sum[3] = -62'(r3_self[3]) + 62'(r3_m[3]) + PQ_RND;
        for (int k = 0; k < 4; k++) begin
            w_rnd[k] = 38'(w_sum[k] >>> 24);
            if (w_rnd[k] > SAT_HI) begin
                w_sat[k] = 32'sh7FFFFFFF;
            end else if (w_rnd[k] < SAT_LO) begin
                w_sat[k] = 32'sh80000000;
            end else begin
                w_sat[k] = w_rnd[k][31:0];
            end
        end
        w_sq[0] = r4_pq.pf * r4_pq.pf;
        w_sq[1] = r4_pq.qf * r4_pq.qf;
        w_sq[2] = r4_pq.pt * r4_pq.pt;
        w_sq[3] = r4_pq.qt * r4_pq.qt;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_line <= i_line;
            r1_p[0] <= i_line.gft * w_c;
            r1_p[1] <= i_line.bft * w_s;
            r1_p[2] <= i_line.bft * w_c;
            r1_p[3] <= i_line.gft * w_s;
            r1_p[4] <= i_line.gtf * w_c;
            r1_p[5] <= i_line.btf * w_s;
            r1_p[6] <= i_line.btf * w_c;
            r1_p[7] <= i_line.gtf * w_s;

            for (int k = 0; k < 4; k++) begin
                r2_br[k] <= w_br[k][57:30];
            end
            r2_self[0] <= 57'(r1_line.gff * $signed({1'b0, r1_line.vf2}));
            r2_self[1] <= 57'(r1_line.bff * $signed({1'b0, r1_line.vf2}));
            r2_self[2] <= 57'(r1_line.gtt * $signed({1'b0, r1_line.vt2}));
            r2_self[3] <= 57'(r1_line.btt * $signed({1'b0, r1_line.vt2}));
            r2_vv      <= r1_line.vv;

            for (int k = 0; k < 4; k++) begin
                r3_m[k]    <= 61'($signed({1'b0, r2_vv}) * r2_br[k]);
                r3_self[k] <= r2_self[k];
            end

            r4_pq.pf <= w_sat[0];
            r4_pq.qf <= w_sat[1];
            r4_pq.pt <= w_sat[2];
            r4_pq.qt <= w_sat[3];

            r5_pq <= r4_pq;
            for (int k = 0; k < 4; k++) begin
                r5_sq[k] <= w_sq[k][62:0];
            end

            r6_sq.pq    <= r5_pq;
            r6_sq.rem_f <= {1'b0, r5_sq[0]} + {1'b0, r5_sq[1]};
            r6_sq.rem_t <= {1'b0, r5_sq[2]} + {1'b0, r5_sq[3]};
            r6_sq.rt_f  <= '0;
            r6_sq.rt_t  <= '0;
        end
    end

    assign o_sq = r6_sq;
endmodule

// ===== hw/rtl/bpf_sqrt_cell.sv =====
// one root digit cell for both ends, carries the flows alongside
module bpf_sqrt_cell #(
    parameter int unsigned K = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  bpf_pkg::t_sq  i_sq,
    output bpf_pkg::t_sq  o_sq
);
    import bpf_pkg::*;

    localparam logic [65:0] SQ_BIT   = 66'd1 << (2 * K);
    localparam logic [31:0] ROOT_BIT = 32'd1 << K;

    t_sq r_sq, n_sq;
    logic [65:0] w_trf, w_trt;

    always_comb begin
        // (root + 2^k)^2 - root^2 against what is left
        w_trf = ({34'd0, i_sq.rt_f} << (K + 1)) + SQ_BIT;
        w_trt = ({34'd0, i_sq.rt_t} << (K + 1)) + SQ_BIT;
        n_sq  = i_sq;
        if ({2'b00, i_sq.rem_f} >= w_trf) begin
            n_sq.rem_f = i_sq.rem_f - w_trf[63:0];
            n_sq.rt_f  = i_sq.rt_f | ROOT_BIT;
        end
        if ({2'b00, i_sq.rem_t} >= w_trt) begin
            n_sq.rem_t = i_sq.rem_t - w_trt[63:0];
            n_sq.rt_t  = i_sq.rt_t | ROOT_BIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;
endmodule

// ===== hw/rtl/bpf_checker.sv =====
// port level checks for the branch power flow block and their bind
module bpf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic signed [31:0]  o_p_from,
    input logic signed [31:0]  o_q_to,
    input logic        [30:0]  o_s_from,
    input logic        [30:0]  o_s_to
);
    // no result straight after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_p_from) && $stable(o_s_from))
        else $error("stalled result changed");

    // apparent power never below a positive real flow
    a_s_from: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_p_from[31] |-> {1'b0, o_s_from} >= o_p_from[31:0])
        else $error("s_from below p_from");

    // apparent power never below a positive reactive flow
    a_s_to: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_q_to[31] |-> {1'b0, o_s_to} >= o_q_to[31:0])
        else $error("s_to below q_to");
endmodule

bind branch_power_flow_eval bpf_checker u_bpf_checker (.*);

// ===== verif/testbench.sv =====
// self-checking regression bench for the ac branch power flow evaluator
`timescale 1ns / 100ps

module testbench;

    import bpf_pkg::*;

    localparam int LATENCY     = PIPE_STAGES;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIRECT_LEN  = 24;

    // 2pi and friends rounded to q.24, angle step atan(2^-i) in q.24
    localparam longint TURN      = 105414357;
    localparam longint HALF_TURN = 52707179;
    localparam longint QUARTER   = 26353589;
    localparam longint ROT_GAIN  = 652032874;

    typedef struct {
        logic signed [23:0] gff, bff, gft, bft, gtf, btf, gtt, btt;
        logic        [15:0] vf, vt;
        logic signed [15:0] af, at;
    } t_line_req;

    typedef struct {
        logic signed [31:0] pf, qf, pt, qt;
        logic        [30:0] sf, st;
    } t_flow_res;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               req_valid = 1'b0;
    logic               req_ready;
    logic signed [23:0] gff = '0, bff = '0, gft = '0, bft = '0;
    logic signed [23:0] gtf = '0, btf = '0, gtt = '0, btt = '0;
    logic        [15:0] vf = '0, vt = '0;
    logic signed [15:0] af = '0, at = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic signed [31:0] p_from, q_from, p_to, q_to;
    logic        [30:0] s_from, s_to;

    t_flow_res flows_due[$];
    int        mismatches = 0;
    longint    cycles = 0;
    bit        calm = 1'b0;   // no stalls in the closing stretch
    int        hold_left = 0; // cycles left in the current output stall

    branch_power_flow_eval dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_g_from_from(gff), .i_b_from_from(bff),
        .i_g_from_to(gft), .i_b_from_to(bft),
        .i_g_to_from(gtf), .i_b_to_from(btf),
        .i_g_to_to(gtt), .i_b_to_to(btt),
        .i_vmag_from(vf), .i_vmag_to(vt),
        .i_angle_from(af), .i_angle_to(at),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_p_from(p_from), .o_q_from(q_from), .o_p_to(p_to), .o_q_to(q_to),
        .o_s_from(s_from), .o_s_to(s_to)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("branch_power_flow_eval regression: fail");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;   // arithmetic shift on a signed longint floors
    endfunction

    function automatic longint atan_step(int i);
        longint tab [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    // rotate the gain vector by the angle difference, cos and sin in q1.30
    function automatic void rotate(input longint ang, output longint cs,
                                   output longint sn);
        longint z, x, y, nx;
        bit     mirror;
        z = ang;
        x = ROT_GAIN;
        y = 0;
        mirror = 1'b0;
        if (z > HALF_TURN) z -= TURN;
        if (z < -HALF_TURN) z += TURN;
        // fold into the right half plane, negating both outputs
        if (z > QUARTER) begin
            z -= HALF_TURN;
            mirror = 1'b1;
        end else if (z < -QUARTER) begin
            z += HALF_TURN;
            mirror = 1'b1;
        end
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z -= atan_step(i);
            end else begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z += atan_step(i);
            end
            x = nx;
        end
        cs = mirror ? -x : x;
        sn = mirror ? -y : y;
    endfunction

    function automatic longint end_power(longint self_adm, longint vsq, longint vv,
                                         longint a, longint c, longint b, longint s);
        longint br, r;
        br = floor_shift(a * c + b * s + (longint'(1) << 29), 30);
        r  = floor_shift(self_adm * vsq + vv * br + (longint'(1) << 23), 24);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    // rounded integer square root of p^2+q^2, capped at 31 bits
    function automatic logic [30:0] apparent(longint p, longint q);
        logic [63:0] n, r, b;
        n = p * p + q * q;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (n > r) r++;
        if (r > 64'd2147483647) r = 64'd2147483647;
        return r[30:0];
    endfunction

    function automatic t_flow_res line_flows(t_line_req l);
        t_flow_res f;
        longint c, s, vv, vf2, vt2, pf, qf, pt, qt;
        rotate((longint'(l.af) - longint'(l.at)) * 2048, c, s);
        vv  = longint'(l.vf) * longint'(l.vt);
        vf2 = longint'(l.vf) * longint'(l.vf);
        vt2 = longint'(l.vt) * longint'(l.vt);
        pf = end_power(l.gff, vf2, vv, l.gft, c, l.bft, s);
        qf = end_power(-longint'(l.bff), vf2, vv, -longint'(l.bft), c, l.gft, s);
        pt = end_power(l.gtt, vt2, vv, l.gtf, c, l.btf, -s);
        qt = end_power(-longint'(l.btt), vt2, vv, -longint'(l.btf), c, l.gtf, -s);
        f.pf = pf[31:0];
        f.qf = qf[31:0];
        f.pt = pt[31:0];
        f.qt = qt[31:0];
        f.sf = apparent(pf, qf);
        f.st = apparent(pt, qt);
        return f;
    endfunction

    // ---------------- request side ----------------

    task automatic idle_burst();
        repeat ($urandom_range(1, 12)) @(negedge clk);
    endtask

    // present one line request and hold it until accepted
    task automatic send_line(t_line_req l);
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            idle_burst();
        end
        req_valid <= 1'b1;
        gff <= l.gff; bff <= l.bff; gft <= l.gft; bft <= l.bft;
        gtf <= l.gtf; btf <= l.btf; gtt <= l.gtt; btt <= l.btt;
        vf <= l.vf; vt <= l.vt; af <= l.af; at <= l.at;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        flows_due.push_back(line_flows(l));
        @(negedge clk);
    endtask

    function automatic logic signed [23:0] rand_adm();
        case ($urandom_range(0, 5))
            0:       return 24'sh7fffff;
            1:       return 24'sh800000;
            2:       return 24'(signed'($urandom_range(0, 2 ** 16)) - 2 ** 15);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_line_req rand_line();
        t_line_req l;
        l.gff = rand_adm(); l.bff = rand_adm(); l.gft = rand_adm(); l.bft = rand_adm();
        l.gtf = rand_adm(); l.btf = rand_adm(); l.gtt = rand_adm(); l.btt = rand_adm();
        // mostly near nominal voltage, sometimes anywhere
        if ($urandom_range(0, 3) == 0) begin
            l.vf = 16'($urandom);
            l.vt = 16'($urandom);
        end else begin
            l.vf = 16'($urandom_range(14000, 19000));
            l.vt = 16'($urandom_range(14000, 19000));
        end
        l.af = 16'($urandom);
        l.at = 16'($urandom);
        return l;
    endfunction

    // ---------------- result side ----------------

    // downstream stalls come in bursts whose length is drawn at random, except in reset and the calm stretch
    always @(negedge clk) begin
        if (!rst_n || calm) begin
            hold_left = 0;
            res_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 11);
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_flow_res e;
        if (rst_n && res_valid && res_ready) begin
            if (flows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result p_from=%0d", p_from);
            end else begin
                e = flows_due.pop_front();
                if (p_from !== e.pf || q_from !== e.qf || p_to !== e.pt ||
                    q_to !== e.qt || s_from !== e.sf || s_to !== e.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp p/q/p/q/s/s %0d %0d %0d %0d %0d %0d",
                                  " got %0d %0d %0d %0d %0d %0d"},
                                 e.pf, e.qf, e.pt, e.qt, e.sf, e.st,
                                 p_from, q_from, p_to, q_to, s_from, s_to);
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_extremes();
        t_line_req l;
        for (int k = 0; k < DIRECT_LEN; k++) begin
            l = rand_line();
            case (k % 8)
                0: begin   // admittances and voltages at their most positive
                    {l.gff, l.bff, l.gft, l.bft} = {4{24'sh7fffff}};
                    {l.gtf, l.btf, l.gtt, l.btt} = {4{24'sh7fffff}};
                    l.vf = 16'hffff; l.vt = 16'hffff;
                end
                1: begin   // most negative admittances, saturation the other way
                    {l.gff, l.bff, l.gft, l.bft} = {4{24'sh800000}};
                    {l.gtf, l.btf, l.gtt, l.btt} = {4{24'sh800000}};
                    l.vf = 16'hffff; l.vt = 16'hffff;
                end
                2: begin   // zero voltage
                    l.vf = 16'h0; l.vt = 16'h0;
                end
                3: begin   // widest angle differences, both wraps
                    l.af = 16'sh7fff; l.at = 16'sh8000;
                end
                4: begin
                    l.af = 16'sh8000; l.at = 16'sh7fff;
                end
                5: begin   // equal angles
                    l.at = l.af;
                end
                6: begin   // near the quarter turn fold
                    l.af = 16'(12868 + int'($urandom_range(0, 4)) - 2);
                    l.at = 16'sh0;
                end
                default: begin   // all zero
                    l = '{default: '0};
                end
            endcase
            send_line(l);
        end
    endtask

    task automatic wait_drained();
        while (flows_due.size() != 0) @(negedge clk);
    endtask

    task automatic test_random_lines(int n);
        for (int k = 0; k < n; k++) send_line(rand_line());
    endtask

    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        req_valid <= 1'b0;
        wait_drained();   // sender holds off until every result is back
        idle_burst();
        test_random_lines(1400);
        calm = 1'b1;
        test_random_lines(200);
        req_valid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);
        if (mismatches == 0 && flows_due.size() == 0)
            $display("branch_power_flow_eval regression: pass");
        else
            $display("branch_power_flow_eval regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bpf_pkg.sv
hw/rtl/bpf_cordic_cell.sv
hw/rtl/bpf_flow.sv
hw/rtl/bpf_sqrt_cell.sv
hw/rtl/branch_power_flow_eval.sv
hw/rtl/bpf_checker.sv
verif/testbench.sv
